// ===== hw/rtl/llpa_pkg.sv =====
// Package for the least-loaded path assigner: field widths and item codes.
// Depends on nothing; the interfaces and the assigner take names from here.
package llpa_pkg;

    // Widths of the item and result fields.
    localparam int FUNC_W      = 1;
    localparam int INDEX_W     = 4;
    localparam int LENGTH_W    = 12;
    localparam int CHOSEN_W    = 4;
    localparam int PATH_LOAD_W = 16;
    localparam int COUNT_W     = 5;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 1'b1;

endpackage

// ===== hw/rtl/llpa_item_if.sv =====
// Input channel of the least-loaded path assigner: valid/ready plus item fields.
// Depends on llpa_pkg for field widths.
interface llpa_item_if;
    logic                             valid;
    logic                             ready;
    logic [llpa_pkg::FUNC_W-1:0]      func;
    logic [llpa_pkg::INDEX_W-1:0]     path_index;
    logic [llpa_pkg::LENGTH_W-1:0]    path_length;

    modport source (output valid, func, path_index, path_length, input ready);
    modport sink   (input valid, func, path_index, path_length, output ready);
endinterface

// ===== hw/rtl/llpa_result_if.sv =====
// Output channel of the least-loaded path assigner: valid/ready plus result fields.
// Depends on llpa_pkg for field widths.
interface llpa_result_if;
    logic                               valid;
    logic                               ready;
    logic [llpa_pkg::CHOSEN_W-1:0]      chosen_path;
    logic [llpa_pkg::PATH_LOAD_W-1:0]   path_load;
    logic                               no_path;

    modport source (output valid, chosen_path, path_load, no_path, input ready);
    modport sink   (input valid, chosen_path, path_load, no_path, output ready);
endinterface

// ===== hw/rtl/llpa_min_unit.sv =====
// Shared cost unit: adds length and count of one entry and keeps the running minimum.
// Stand-alone; used by least_loaded_path_assigner during its table scan.
module llpa_min_unit #(
    parameter int LENGTH_BITS = 12,
    parameter int LOAD_BITS   = 16,
    parameter int IDX_W       = 4
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic                   first,
    input  logic [IDX_W-1:0]       idx,
    input  logic [LENGTH_BITS-1:0] len,
    input  logic [LOAD_BITS-1:0]   load,
    input  logic                   load_ok,
    output logic [IDX_W-1:0]       best_idx,
    output logic [LOAD_BITS-1:0]   best_load
);

    localparam int COST_W = ((LENGTH_BITS > LOAD_BITS) ? LENGTH_BITS : LOAD_BITS) + 1;

    logic [IDX_W-1:0]     best_idx_reg;
    logic [LOAD_BITS-1:0] best_load_reg;
    logic [COST_W-1:0]    best_cost_reg;
    logic [LOAD_BITS-1:0] load_eff;
    logic [COST_W-1:0]    cost;
    logic                 take;

    // A count that was cleared or never written reads as zero.
    assign load_eff = load_ok ? load : '0;
    assign cost     = COST_W'(len) + COST_W'(load_eff);

    // Strictly smaller wins, so ties stay with the lower index.
    assign take = first || (cost < best_cost_reg);

    always_ff @(posedge clk)
    begin
        if (en && take)
        begin
            best_idx_reg  <= idx;
            best_load_reg <= load_eff;
            best_cost_reg <= cost;
        end
    end

    assign best_idx  = best_idx_reg;
    assign best_load = best_load_reg;

endmodule

// ===== hw/rtl/least_loaded_path_assigner.sv =====
// Least-loaded path assigner: a load item gives no result. An assign item scans
// the first path_count entries, at most MAX_PATHS, through one shared cost unit,
// one table read per cycle, then offers its result from the finish step; with no
// paths in use it skips the scan and gives a no-path result. The next item is
// taken once the result is registered. Reset clears path_count, all counts and control.
module least_loaded_path_assigner #(
    parameter int MAX_PATHS   = 16,
    parameter int LENGTH_BITS = 12,
    parameter int LOAD_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [llpa_pkg::COUNT_W-1:0]   cfg_wdata,
    llpa_item_if.sink                      items,
    llpa_result_if.source                  results
);

    localparam int IDX_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
    localparam int CNT_W = $clog2(MAX_PATHS + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [llpa_pkg::COUNT_W-1:0]    path_count_reg;
    logic [CNT_W-1:0]                used_reg, used_next;
    logic [CNT_W-1:0]                scan_idx_reg;
    logic                            no_path_pend_reg;

    logic [LENGTH_BITS-1:0]          len_mem [MAX_PATHS];
    logic [LOAD_BITS-1:0]            load_mem [MAX_PATHS];
    logic [MAX_PATHS-1:0]            load_vld_reg;

    logic [LENGTH_BITS-1:0]          len_rd_reg;
    logic [LOAD_BITS-1:0]            load_rd_reg;
    logic                            vld_rd_reg;
    logic                            cmp_valid_reg;
    logic [IDX_W-1:0]                cmp_idx_reg;

    logic                            out_valid_reg;
    logic [llpa_pkg::CHOSEN_W-1:0]   chosen_reg;
    logic [llpa_pkg::PATH_LOAD_W-1:0] path_load_reg;
    logic                            no_path_reg;

    logic                            in_xfer;
    logic                            load_xfer;
    logic                            assign_xfer;
    logic                            load_in_range;
    logic                            rd_issue;
    logic [IDX_W-1:0]                rd_addr;
    logic                            finish_go;
    logic [IDX_W-1:0]                best_idx;
    logic [LOAD_BITS-1:0]            best_load;
    logic [LOAD_BITS-1:0]            new_load;

    // Input handshake.
    assign items.ready   = (state_reg == ST_IDLE);
    assign in_xfer       = items.valid && items.ready;
    assign load_xfer     = in_xfer && (items.func == llpa_pkg::FUNC_LOAD);
    assign assign_xfer   = in_xfer && (items.func == llpa_pkg::FUNC_ASSIGN);
    assign load_in_range = (32'(items.path_index) < 32'(MAX_PATHS));

    // Entries in use, limited to the table depth.
    always_comb
    begin
        if (32'(path_count_reg) > 32'(MAX_PATHS))
            used_next = CNT_W'(MAX_PATHS);
        else
            used_next = CNT_W'(path_count_reg);
    end

    // Scan read issue and the end of the scan.
    assign rd_issue  = (state_reg == ST_SCAN) && (scan_idx_reg < used_reg);
    assign rd_addr   = scan_idx_reg[IDX_W-1:0];
    assign finish_go = !out_valid_reg || results.ready;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (assign_xfer)
                    state_next = (used_next == '0) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == used_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (finish_go)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            path_count_reg   <= '0;
            used_reg         <= '0;
            scan_idx_reg     <= '0;
            no_path_pend_reg <= 1'b0;
            cmp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= rd_issue;
            if (cfg_we)
                path_count_reg <= cfg_wdata;
            if (assign_xfer)
            begin
                used_reg         <= used_next;
                scan_idx_reg     <= '0;
                no_path_pend_reg <= (used_next == '0);
            end
            else if (rd_issue)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    // Length table: written by load items, read once per scan step.
    always_ff @(posedge clk)
    begin
        if (load_xfer && load_in_range)
            len_mem[IDX_W'(items.path_index)] <= LENGTH_BITS'(items.path_length);
        if (rd_issue)
            len_rd_reg <= len_mem[rd_addr];
    end

    // Count table: written back after each assignment, read once per scan step.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && finish_go && !no_path_pend_reg)
            load_mem[best_idx] <= new_load;
        if (rd_issue)
        begin
            load_rd_reg <= load_mem[rd_addr];
            vld_rd_reg  <= load_vld_reg[rd_addr];
            cmp_idx_reg <= rd_addr;
        end
    end

    // Count valid bits: a cleared count reads as zero until written back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_vld_reg <= '0;
        else
        begin
            if (load_xfer && load_in_range)
                load_vld_reg[IDX_W'(items.path_index)] <= 1'b0;
            else if ((state_reg == ST_FINISH) && finish_go && !no_path_pend_reg)
                load_vld_reg[best_idx] <= 1'b1;
        end
    end

    // Shared cost and minimum unit.
    llpa_min_unit #(
        .LENGTH_BITS (LENGTH_BITS),
        .LOAD_BITS   (LOAD_BITS),
        .IDX_W       (IDX_W)
    ) u_min (
        .clk       (clk),
        .en        (cmp_valid_reg),
        .first     (cmp_idx_reg == '0),
        .idx       (cmp_idx_reg),
        .len       (len_rd_reg),
        .load      (load_rd_reg),
        .load_ok   (vld_rd_reg),
        .best_idx  (best_idx),
        .best_load (best_load)
    );

    // Saturating increment of the chosen count.
    assign new_load = (best_load == {LOAD_BITS{1'b1}}) ? best_load : best_load + 1'b1;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == ST_FINISH) && finish_go)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && finish_go)
        begin
            if (no_path_pend_reg)
            begin
                chosen_reg    <= '0;
                path_load_reg <= '0;
                no_path_reg   <= 1'b1;
            end
            else
            begin
                chosen_reg    <= llpa_pkg::CHOSEN_W'(best_idx);
                path_load_reg <= llpa_pkg::PATH_LOAD_W'(new_load);
                no_path_reg   <= 1'b0;
            end
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.chosen_path = chosen_reg;
    assign results.path_load   = path_load_reg;
    assign results.no_path     = no_path_reg;

    // A result only appears when the sequencer finishes an item.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    // A no-path result carries zero fields.
    a_no_path_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.no_path) |->
            (results.chosen_path == '0 && results.path_load == '0))
        else $error("no-path result with nonzero fields");

    // An accepted assign item always leaves idle.
    a_assign_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        assign_xfer |=> (state_reg != ST_IDLE))
        else $error("assign transfer did not start the sequencer");

    // The scan pointer never runs past the entries in use.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= used_reg))
        else $error("scan pointer beyond entries in use");

endmodule
